// ----- sv/caf_pkg.sv -----
// ============================================================================
// caf_pkg
// Shared types and constants of the complementary attitude filter.
// ============================================================================
package caf_pkg;

    // CORDIC lane widths: x/y hold the grown vector, z holds the Q.24 angle.
    localparam int XW = 20;
    localparam int ZW = 28;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME    = 2'd1;

    localparam logic [15:0] BLEND_WEIGHT_RST = 16'd64225;
    localparam logic [15:0] STEP_TIME_RST    = 16'd164;

    localparam logic signed [ZW-1:0] PI_Q24 = 28'sd52707179;

    // Datapath commands issued by the controller
    typedef struct packed {
        logic load;
        logic iter;
        logic round;
        logic pred;
        logic mul;
        logic commit;
    } t_dp_cmd;

    // Datapath status returned to the controller
    typedef struct packed {
        logic last_step;
    } t_dp_stat;

    // atan(2^-i) in Q.24, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_q24(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            5'd0:    v = 28'sd13176795;
            5'd1:    v = 28'sd7778716;
            5'd2:    v = 28'sd4110060;
            5'd3:    v = 28'sd2086331;
            5'd4:    v = 28'sd1047214;
            5'd5:    v = 28'sd524117;
            5'd6:    v = 28'sd262123;
            5'd7:    v = 28'sd131069;
            5'd8:    v = 28'sd65536;
            5'd9:    v = 28'sd32768;
            5'd10:   v = 28'sd16384;
            5'd11:   v = 28'sd8192;
            5'd12:   v = 28'sd4096;
            5'd13:   v = 28'sd2048;
            5'd14:   v = 28'sd1024;
            5'd15:   v = 28'sd512;
            5'd16:   v = 28'sd256;
            5'd17:   v = 28'sd128;
            5'd18:   v = 28'sd64;
            5'd19:   v = 28'sd32;
            5'd20:   v = 28'sd16;
            5'd21:   v = 28'sd8;
            5'd22:   v = 28'sd4;
            5'd23:   v = 28'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/caf_in_if.sv -----
// ============================================================================
// caf_in_if
// IMU sample channel: two gyro rates and three accelerometer axes.
// ============================================================================
interface caf_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_y;
    logic signed [15:0] acc_z;

    modport source (output valid, output rate_x, output rate_y, output acc_x,
                    output acc_y, output acc_z, input ready);
    modport sink   (input valid, input rate_x, input rate_y, input acc_x,
                    input acc_y, input acc_z, output ready);
endinterface

// ----- sv/caf_out_if.sv -----
// ============================================================================
// caf_out_if
// Filtered attitude channel: roll and pitch in Q2.13 radians.
// ============================================================================
interface caf_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;

    modport source (output valid, output roll_angle, output pitch_angle, input ready);
    modport sink   (input valid, input roll_angle, input pitch_angle, output ready);
endinterface

// ----- sv/caf_ctrl.sv -----
// ============================================================================
// caf_ctrl
// Sequencer: load, CORDIC iterations, rounding, blend stages, commit.
// ============================================================================
module caf_ctrl
    import caf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ITER  = 6'b000010,
        S_ROUND = 6'b000100,
        S_PRED  = 6'b001000,
        S_MUL   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = i_in_valid && (r_state == S_IDLE);
        o_cmd.iter   = (r_state == S_ITER);
        o_cmd.round  = (r_state == S_ROUND);
        o_cmd.pred   = (r_state == S_PRED);
        o_cmd.mul    = (r_state == S_MUL);
        o_cmd.commit = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_ITER;
            S_ITER:  if (i_stat.last_step) n_state = S_ROUND;
            S_ROUND: n_state = S_PRED;
            S_PRED:  n_state = S_MUL;
            S_MUL:   n_state = S_DONE;
            S_DONE:  if (o_cmd.commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- sv/caf_dp.sv -----
// ============================================================================
// caf_dp
// Datapath: two CORDIC vectoring lanes (roll, pitch) sharing one step
// counter, then a staged fixed-point blend with the stored estimates.
// ============================================================================
module caf_dp
    import caf_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic signed [15:0]    i_rate_x,
    input  logic signed [15:0]    i_rate_y,
    input  logic signed [15:0]    i_acc_x,
    input  logic signed [15:0]    i_acc_y,
    input  logic signed [15:0]    i_acc_z,
    output logic signed [15:0]    o_roll_angle,
    output logic signed [15:0]    o_pitch_angle
);

    localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [CW-1:0] LAST_STEP = CW'(CORDIC_STEPS - 1);

    logic [15:0]   r_alpha;
    logic [15:0]   r_dt;
    logic [CW-1:0] r_step;
    logic [16:0]   w_w2;

    logic signed [16:0] w_ly [2];
    logic signed [16:0] w_lx [2];
    logic signed [15:0] w_lrate [2];
    logic signed [15:0] w_out [2];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= BLEND_WEIGHT_RST;
            r_dt    <= STEP_TIME_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BLEND_WEIGHT: r_alpha <= i_cfg_data;
                CFG_STEP_TIME:    r_dt    <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    // Shared iteration counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_cmd.load) begin
            r_step <= '0;
        end else if (i_cmd.iter && (r_step != LAST_STEP)) begin
            r_step <= r_step + 1'b1;
        end
    end

    assign o_stat.last_step = (r_step == LAST_STEP);

    // Accelerometer weight 1 - alpha, 1..65536
    assign w_w2 = 17'h10000 - {1'b0, r_alpha};

    // Lane inputs: roll uses (acc_y, acc_z), pitch uses (-acc_x, acc_z)
    assign w_ly[0]    = 17'(i_acc_y);
    assign w_ly[1]    = -17'(i_acc_x);
    assign w_lx[0]    = 17'(i_acc_z);
    assign w_lx[1]    = 17'(i_acc_z);
    assign w_lrate[0] = i_rate_x;
    assign w_lrate[1] = i_rate_y;

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic signed [XW-1:0] r_cx, r_cy;
        logic signed [ZW-1:0] r_cz;
        logic                 r_zero;
        logic signed [15:0]   r_rate;
        logic signed [15:0]   r_acc_ang;
        logic signed [32:0]   r_prod;
        logic signed [34:0]   r_pred;
        logic signed [33:0]   r_accw;
        logic signed [51:0]   r_gp;
        logic signed [15:0]   r_est;
        logic signed [15:0]   r_out;

        logic signed [XW-1:0] w_dx, w_dy;
        logic signed [ZW-1:0] w_atan, w_zr;
        logic signed [34:0]   w_pred_a;
        logic signed [47:0]   w_accs;
        logic signed [52:0]   w_sum;
        logic signed [22:0]   w_sh;
        logic signed [15:0]   w_sat;

        assign w_dx     = r_cy >>> r_step;
        assign w_dy     = r_cx >>> r_step;
        assign w_atan   = atan_q24(5'(r_step));
        assign w_zr     = (r_cz + ZW'(1024)) >>> 11;
        assign w_pred_a = {{5{r_est[15]}}, r_est, 14'b0};
        assign w_accs   = {r_accw, 14'b0};
        assign w_sum    = 53'(r_gp) + 53'(w_accs) + 53'sh2000_0000;
        assign w_sh     = 23'(w_sum >>> 30);

        always_comb begin
            if (w_sh > 23'sd32767) begin
                w_sat = 16'sh7FFF;
            end else if (w_sh < -23'sd32768) begin
                w_sat = 16'sh8000;
            end else begin
                w_sat = w_sh[15:0];
            end
        end

        // CORDIC vectoring and blend pipeline registers
        always_ff @(posedge i_clk) begin
            if (i_cmd.load) begin
                r_rate <= w_lrate[l];
                r_zero <= (w_lx[l] == '0) && (w_ly[l] == '0);
                if (w_lx[l] < 0) begin
                    // rotate by pi into the right half plane
                    r_cz <= (w_ly[l] >= 0) ? PI_Q24 : -PI_Q24;
                    r_cx <= -XW'(w_lx[l]);
                    r_cy <= -XW'(w_ly[l]);
                end else begin
                    r_cz <= '0;
                    r_cx <= XW'(w_lx[l]);
                    r_cy <= XW'(w_ly[l]);
                end
            end else if (i_cmd.iter) begin
                if (r_cy > 0) begin
                    r_cx <= r_cx + w_dx;
                    r_cy <= r_cy - w_dy;
                    r_cz <= r_cz + w_atan;
                end else begin
                    r_cx <= r_cx - w_dx;
                    r_cy <= r_cy + w_dy;
                    r_cz <= r_cz - w_atan;
                end
            end
            if (i_cmd.round) begin
                r_acc_ang <= r_zero ? '0 : w_zr[15:0];
                r_prod    <= r_rate * $signed({1'b0, r_dt});
            end
            if (i_cmd.pred) begin
                r_pred <= w_pred_a + 35'(r_prod);
                r_accw <= $signed({1'b0, w_w2}) * r_acc_ang;
            end
            if (i_cmd.mul) begin
                r_gp <= $signed({1'b0, r_alpha}) * r_pred;
            end
            if (i_cmd.commit) begin
                r_out <= w_sat;
            end
        end

        // Stored estimate
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_est <= '0;
            end else if (i_cmd.commit) begin
                r_est <= w_sat;
            end
        end

        assign w_out[l] = r_out;
    end

    assign o_roll_angle  = w_out[0];
    assign o_pitch_angle = w_out[1];

endmodule

// ----- sv/complementary_attitude_filter_unit.sv -----
// ============================================================================
// complementary_attitude_filter_unit
// Roll/pitch complementary filter: CORDIC atan2 of the accelerometer vector
// blended with the gyro-propagated previous estimate.
// ============================================================================
//
//  channel   dir  transfer when   payload
//  --------  ---  --------------  ----------------------------------------
//  i_in_ch   in   valid && ready  rate_x, rate_y, acc_x, acc_y, acc_z
//  o_out_ch  out  valid && ready  roll_angle, pitch_angle (Q2.13 rad)
//  i_cfg_*   in   i_cfg_we        0: blend_weight, 1: step_time (Q0.16)
//
//  Between one input transfer and the next, a sample passes through the
//  accepting idle cycle, the shared CORDIC iteration counter, three
//  rounding/multiply stages and the commit cycle. The result sits in an
//  output register; the next sample is taken while it waits, and only the
//  commit of that next sample holds on a full output.
//  Synchronous active-low reset clears the estimates and restores the
//  register defaults (alpha 0.98, dt 1/400 s).
//
module complementary_attitude_filter_unit
    import caf_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    caf_in_if.sink                i_in_ch,
    caf_out_if.source             o_out_ch,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequencer: handshakes and stage commands
    caf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_ch.valid),
        .o_in_ready  (i_in_ch.ready),
        .o_out_valid (o_out_ch.valid),
        .i_out_ready (o_out_ch.ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    // Arithmetic: both CORDIC lanes, blend, estimates and result register
    caf_dp #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_rate_x      (i_in_ch.rate_x),
        .i_rate_y      (i_in_ch.rate_y),
        .i_acc_x       (i_in_ch.acc_x),
        .i_acc_y       (i_in_ch.acc_y),
        .i_acc_z       (i_in_ch.acc_z),
        .o_roll_angle  (o_out_ch.roll_angle),
        .o_pitch_angle (o_out_ch.pitch_angle)
    );

    // Commit never overwrites a result still waiting for its transfer
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> (!o_out_ch.valid || o_out_ch.ready))
        else $error("commit into an occupied output register");

    // A committed result is presented on the next cycle
    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> o_out_ch.valid)
        else $error("committed result not presented");

    // One sample at a time: ready drops after every input transfer
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_ch.valid && i_in_ch.ready) |=> !i_in_ch.ready)
        else $error("second sample taken while one is in flight");

    // Loading is never commanded together with committing or iterating
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.load && (w_cmd.commit || w_cmd.iter)))
        else $error("load overlaps a busy stage");

endmodule
